/* design/servo_pid_sliding_mode_controller_macros.svh */
// assertion macros shared by the servo controller checkers
// depends on nothing; included by the checker file
`ifndef SERVO_PID_SLIDING_MODE_CONTROLLER_MACROS_SVH
`define SERVO_PID_SLIDING_MODE_CONTROLLER_MACROS_SVH

// next-cycle implication, quiet while reset is high
`define SPSMC_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("servo controller check failed");

// next-cycle implication that also holds across reset
`define SPSMC_ASSERT_NEXT_ALWAYS(lbl, clk, cond, prop) \
   lbl: assert property (@(posedge clk) (cond) |=> (prop)) \
      else $error("servo controller check failed");

`endif

/* design/spsmc_pkg.sv */
// constants, widths and helpers for the servo pid / sliding-mode controller
// depends on nothing; used by the top level and the checker
`default_nettype none

package spsmc_pkg;

   // history depth and derived widths
   localparam int HISTORY_DEPTH = 16;
   localparam int IDX_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W         = $clog2(2 * HISTORY_DEPTH + 2);
   localparam int STEP_W        = $clog2(HISTORY_DEPTH + 4);
   localparam int ASUM_W        = IDX_W + 2;
   localparam int SUM_W         = 32 + IDX_W + 1;
   localparam int DIV_W         = SUM_W;
   localparam int DCNT_W        = $clog2(DIV_W + 1);
   localparam int SW_W          = 50 + IDX_W;
   localparam int ACC_W         = 56;
   localparam bit DEPTH_POW2    = ((HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0);

   // target jump limit, 10 degrees in q16.16, and its magnitude width
   localparam int JUMP_LIMIT    = 655360;
   localparam int SLOPE_BITS    = 20;

   // register indexes
   localparam logic [2:0] REG_GAIN_P   = 3'd0;
   localparam logic [2:0] REG_GAIN_I   = 3'd1;
   localparam logic [2:0] REG_GAIN_VFB = 3'd2;
   localparam logic [2:0] REG_GAIN_VFF = 3'd3;
   localparam logic [2:0] REG_GAIN_AFF = 3'd4;
   localparam logic [2:0] REG_SMC      = 3'd5;
   localparam logic [2:0] REG_STAT_BND = 3'd6;
   localparam logic [2:0] REG_ONED_BND = 3'd7;

   // clamp a wide signed value to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      logic signed [31:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* design/servo_pid_sliding_mode_controller.sv */
// servo position controller: pid with feed-forward and a sliding-mode term
// depends on spsmc_pkg
//
// usage
//  req channel: tdata = target_position [31:0], measured_position [63:32].
//  rsp channel: tdata = drive_value [31:0], one response per request.
//  csr channel: csr_index selects one of eight registers, csr_wdata is the
//  value; csr_ready is always high; write only while the block is idle.
//  steps in order: the target tracker update, the serial slope divider
//  (one quotient bit a cycle) when the target changed, the extrapolation
//  step, a walk over the two history memories (one entry a cycle through
//  each memory read port), the mean step, the shared 32x32 multiplier and
//  the output step. One request is worked on at a time, so a new one is
//  taken only after the previous one has left the output step.
//  reset clears all gains, bands, the target tracker and the valid bits of
//  both history memories, so every history entry reads as zero.
//  when the receiver stalls, the result waits in the output register; the
//  next request is taken and worked on, and only its final output step waits.
`default_nettype none

module servo_pid_sliding_mode_controller
   import spsmc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request: target_position [31:0], measured_position [63:32]
   input  wire logic [63:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // response: drive_value [31:0]
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // register writes
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_UPD    = 8'b00000010,
      ST_DIV    = 8'b00000100,
      ST_EXTRAP = 8'b00001000,
      ST_WALK   = 8'b00010000,
      ST_MEAN   = 8'b00100000,
      ST_MUL    = 8'b01000000,
      ST_FIN    = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic signed [31:0] gp_ff, gi_ff, gvfb_ff, gvff_ff, gaff_ff;
   logic [63:0]        smc_ff;
   logic [30:0]        stat_bnd_ff, oned_bnd_ff;

   // tracker state
   logic [IDX_W-1:0]   k_ff;
   logic signed [31:0] latest_ff, prev_ff, slope_ff;
   logic [CNT_W-1:0]   tsc_ff, tbc_ff;

   // request latch
   logic signed [31:0] tgt_in_ff;

   // history memories and valid bits
   logic [31:0]              tgt_mem [HISTORY_DEPTH];
   logic [31:0]              pos_mem [HISTORY_DEPTH];
   logic [HISTORY_DEPTH-1:0] tgt_vld_ff, pos_vld_ff;
   logic [31:0]              tgt_rd_ff, pos_rd_ff;
   logic                     tgt_rdv_ff, pos_rdv_ff;
   logic [IDX_W-1:0]         tgt_raddr, pos_raddr;
   logic                     tgt_we;
   logic signed [31:0]       tgt_wdata;

   // serial divider
   logic [DIV_W-1:0]   dq_ff;
   logic [CNT_W-1:0]   rem_ff, dvs_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic               dneg_ff, dmean_ff;
   logic [CNT_W:0]     rem_sh;
   logic               rem_ge;

   // walk pipeline
   logic [STEP_W-1:0]  cnt_ff;
   logic signed [31:0] err2_ff, d2_ff;
   logic signed [47:0] p1_ff, p2_ff;
   logic signed [48:0] p4_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SW_W-1:0]  sw_ff;
   logic signed [48:0] surfk_ff;
   logic signed [31:0] cp0_ff, cpm1_ff, cpm2_ff, ap0_ff, apm1_ff, e_ff;

   // final arithmetic
   logic signed [31:0] mean_ff, cv_ff, ca_ff, av_ff;
   logic signed [64:0] k3s_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [2:0]         m_ff;

   // response register
   logic [31:0]        rsp_data_ff;
   logic               rsp_valid_ff;

   // handshakes
   logic req_acc, rsp_free;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // sliding-mode gains
   logic signed [15:0] k1, k2, k3, k4;
   assign k1 = smc_ff[15:0];
   assign k2 = smc_ff[31:16];
   assign k3 = smc_ff[47:32];
   assign k4 = smc_ff[63:48];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff       <= '0;
         gi_ff       <= '0;
         gvfb_ff     <= '0;
         gvff_ff     <= '0;
         gaff_ff     <= '0;
         smc_ff      <= '0;
         stat_bnd_ff <= '0;
         oned_bnd_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_GAIN_P:   gp_ff       <= csr_wdata[31:0];
            REG_GAIN_I:   gi_ff       <= csr_wdata[31:0];
            REG_GAIN_VFB: gvfb_ff     <= csr_wdata[31:0];
            REG_GAIN_VFF: gvff_ff     <= csr_wdata[31:0];
            REG_GAIN_AFF: gaff_ff     <= csr_wdata[31:0];
            REG_SMC:      smc_ff      <= csr_wdata;
            REG_STAT_BND: stat_bnd_ff <= csr_wdata[30:0];
            REG_ONED_BND: oned_bnd_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // walk addresses: target at k+s, position one behind
   logic [ASUM_W-1:0] asum;
   logic [ASUM_W-1:0] awrap;
   always_comb begin
      asum  = ASUM_W'(k_ff) + ASUM_W'(cnt_ff);
      awrap = (asum >= ASUM_W'(HISTORY_DEPTH)) ? asum - ASUM_W'(HISTORY_DEPTH) : asum;
      tgt_raddr = awrap[IDX_W-1:0];
      pos_raddr = (awrap == '0) ? IDX_W'(HISTORY_DEPTH - 1) : IDX_W'(awrap - 1'b1);
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (req_acc) begin
         pos_mem[k_ff] <= req_tdata[63:32];
      end
      if (tgt_we) begin
         tgt_mem[k_ff] <= tgt_wdata;
      end
      pos_rd_ff  <= pos_mem[pos_raddr];
      tgt_rd_ff  <= tgt_mem[tgt_raddr];
      pos_rdv_ff <= pos_vld_ff[pos_raddr];
      tgt_rdv_ff <= tgt_vld_ff[tgt_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_vld_ff <= '0;
         tgt_vld_ff <= '0;
      end else begin
         if (req_acc) pos_vld_ff[k_ff] <= 1'b1;
         if (tgt_we)  tgt_vld_ff[k_ff] <= 1'b1;
      end
   end

   // tracker update decision
   logic signed [32:0] tdiff;
   logic               tjump;
   logic [32:0]        tdiff_mag;
   always_comb begin
      tdiff     = 33'(tgt_in_ff) - 33'(latest_ff);
      tjump     = (tsc_ff >= CNT_W'(2 * HISTORY_DEPTH)) ||
                  (tdiff > 33'sd655360) || (tdiff < -33'sd655360);
      tdiff_mag = tdiff[32] ? 33'(-tdiff) : 33'(tdiff);
   end

   // divider step
   always_comb begin
      rem_sh = {rem_ff, dq_ff[DIV_W-1]};
      rem_ge = (rem_sh >= {1'b0, dvs_ff});
   end

   // extrapolated target
   logic signed [CNT_W+1:0] tcnt;
   logic signed [67:0]      extrap;
   always_comb begin
      tcnt      = $signed({2'b00, tsc_ff}) + $signed({2'b00, tbc_ff});
      extrap    = 68'(tcnt * slope_ff) + 68'(prev_ff);
      tgt_wdata = sat32(extrap);
      tgt_we    = (state_ff == ST_EXTRAP);
   end

   // walk stage steps
   logic [STEP_W-1:0]  s1, s2, s3;
   logic               v1, v2, v3;
   logic signed [31:0] cp, ap, err1, d1;
   logic [31:0]        err2_mag;
   logic signed [48:0] surf3;
   always_comb begin
      s1 = cnt_ff - STEP_W'(1);
      s2 = cnt_ff - STEP_W'(2);
      s3 = cnt_ff - STEP_W'(3);
      v1 = (state_ff == ST_WALK) && (cnt_ff >= STEP_W'(1)) &&
           (s1 <= STEP_W'(HISTORY_DEPTH));
      v2 = (state_ff == ST_WALK) && (cnt_ff >= STEP_W'(2)) &&
           (s2 <= STEP_W'(HISTORY_DEPTH));
      v3 = (state_ff == ST_WALK) && (cnt_ff >= STEP_W'(3)) &&
           (s3 <= STEP_W'(HISTORY_DEPTH));
      cp       = tgt_rdv_ff ? tgt_rd_ff : '0;
      ap       = pos_rdv_ff ? pos_rd_ff : '0;
      err1     = sat32(68'(cp) - 68'(ap));
      d1       = sat32(68'(err1) - 68'(err2_ff));
      err2_mag = err2_ff[31] ? 32'(-err2_ff) : 32'(err2_ff);
      surf3    = 49'(p1_ff) + 49'(p2_ff);
   end

   // final stage operands
   logic signed [31:0] cv, cvp, ca, av;
   logic signed [31:0] mul_a, mul_b;
   logic signed [ACC_W-1:0] prod_term;
   always_comb begin
      cv  = sat32(68'(cp0_ff) - 68'(cpm1_ff));
      cvp = sat32(68'(cpm1_ff) - 68'(cpm2_ff));
      ca  = sat32(68'(cv) - 68'(cvp));
      av  = sat32(68'(ap0_ff) - 68'(apm1_ff));
      case (m_ff)
         3'd0:    begin mul_a = gp_ff;   mul_b = e_ff;    end
         3'd1:    begin mul_a = gi_ff;   mul_b = mean_ff; end
         3'd2:    begin mul_a = gvff_ff; mul_b = cv_ff;   end
         3'd3:    begin mul_a = gaff_ff; mul_b = ca_ff;   end
         default: begin mul_a = gvfb_ff; mul_b = av_ff;   end
      endcase
      prod_term = ACC_W'(prod_ff >>> 16);
   end

   // drive value, bands
   logic signed [31:0] drive_sat, drive_out;
   logic [32:0]        e_mag;
   always_comb begin
      drive_sat = sat32(68'(acc_ff));
      e_mag     = e_ff[31] ? 33'(-33'(e_ff)) : 33'(e_ff);
      drive_out = drive_sat;
      if (e_mag < {2'b00, stat_bnd_ff}) begin
         drive_out = '0;
      end else if (e_mag < {2'b00, oned_bnd_ff}) begin
         if (slope_ff < 0 && drive_sat > 0) begin
            drive_out = '0;
         end else if (slope_ff > 0 && drive_sat < 0) begin
            drive_out = '0;
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_acc) state_in = ST_UPD;
         ST_UPD:    state_in = (!tjump && tdiff != '0) ? ST_DIV : ST_EXTRAP;
         ST_DIV:    if (dcnt_ff == '0) state_in = dmean_ff ? ST_MUL : ST_EXTRAP;
         ST_EXTRAP: state_in = ST_WALK;
         ST_WALK:   if (cnt_ff == STEP_W'(HISTORY_DEPTH + 3)) state_in = ST_MEAN;
         ST_MEAN:   state_in = DEPTH_POW2 ? ST_MUL : ST_DIV;
         ST_MUL:    if (m_ff == 3'd5) state_in = ST_FIN;
         ST_FIN:    if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         latest_ff    <= '0;
         prev_ff      <= '0;
         slope_ff     <= '0;
         tsc_ff       <= '0;
         tbc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         m_ff         <= '0;
         dcnt_ff      <= '0;
         dmean_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_UPD: begin
               if (tjump) begin
                  latest_ff <= tgt_in_ff;
                  prev_ff   <= tgt_in_ff;
                  tsc_ff    <= '0;
                  tbc_ff    <= '0;
                  slope_ff  <= '0;
               end else if (tdiff != '0) begin
                  prev_ff   <= latest_ff;
                  latest_ff <= tgt_in_ff;
                  tbc_ff    <= tsc_ff + 1'b1;
                  tsc_ff    <= '0;
                  dcnt_ff   <= DCNT_W'(SLOPE_BITS);
                  dmean_ff  <= 1'b0;
               end else begin
                  tsc_ff <= tsc_ff + 1'b1;
               end
            end
            ST_DIV: begin
               if (dcnt_ff != '0) begin
                  dcnt_ff <= dcnt_ff - 1'b1;
               end else if (!dmean_ff) begin
                  slope_ff <= dneg_ff ? -32'(dq_ff[SLOPE_BITS-1:0])
                                      : 32'(dq_ff[SLOPE_BITS-1:0]);
               end
            end
            ST_EXTRAP: cnt_ff <= '0;
            ST_WALK:   cnt_ff <= cnt_ff + 1'b1;
            ST_MEAN: begin
               m_ff <= '0;
               if (!DEPTH_POW2) begin
                  dcnt_ff  <= DCNT_W'(DIV_W);
                  dmean_ff <= 1'b1;
               end
            end
            ST_MUL: ;
            default: ;
         endcase
         if (state_ff == ST_MUL) m_ff <= m_ff + 1'b1;
         if (state_ff == ST_DIV && dcnt_ff == '0) m_ff <= '0;
         // response valid: set by the output step, cleared when taken
         if (state_ff == ST_FIN && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            k_ff <= (k_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : k_ff + 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) tgt_in_ff <= req_tdata[31:0];

      // divider load and steps
      if (state_ff == ST_UPD) begin
         dq_ff   <= {tdiff_mag[SLOPE_BITS-1:0], (DIV_W - SLOPE_BITS)'(0)};
         dvs_ff  <= tsc_ff + 1'b1;
         rem_ff  <= '0;
         dneg_ff <= tdiff[32];
      end else if (state_ff == ST_MEAN) begin
         dq_ff   <= sum_ff[SUM_W-1] ? DIV_W'(-sum_ff) : DIV_W'(sum_ff);
         dvs_ff  <= CNT_W'(HISTORY_DEPTH);
         rem_ff  <= '0;
         dneg_ff <= sum_ff[SUM_W-1];
      end else if (state_ff == ST_DIV && dcnt_ff != '0) begin
         dq_ff  <= {dq_ff[DIV_W-2:0], rem_ge};
         rem_ff <= rem_ge ? CNT_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[CNT_W-1:0];
      end

      // walk stage 1: error and error change
      if (state_ff == ST_EXTRAP) begin
         sum_ff <= '0;
         sw_ff  <= '0;
      end
      if (v1) begin
         err2_ff <= err1;
         d2_ff   <= d1;
         if (s1 == STEP_W'(HISTORY_DEPTH - 2)) cpm2_ff <= cp;
         if (s1 == STEP_W'(HISTORY_DEPTH - 1)) cpm1_ff <= cp;
         if (s1 == STEP_W'(HISTORY_DEPTH))     cp0_ff  <= cp;
         if (s1 == STEP_W'(0))                 apm1_ff <= ap;
         if (s1 == STEP_W'(1))                 ap0_ff  <= ap;
      end
      // walk stage 2: products, error sum
      if (v2) begin
         p1_ff <= k1 * err2_ff;
         p2_ff <= k2 * d2_ff;
         p4_ff <= k4 * $signed({1'b0, err2_mag});
         if (s2 >= STEP_W'(1)) sum_ff <= sum_ff + SUM_W'(err2_ff);
         if (s2 == STEP_W'(HISTORY_DEPTH)) e_ff <= err2_ff;
      end
      // walk stage 3: surface and switching sum
      if (v3) begin
         if (s3 >= STEP_W'(1)) begin
            sw_ff <= surf3[48] ? sw_ff - SW_W'(p4_ff) : sw_ff + SW_W'(p4_ff);
         end
         if (s3 == STEP_W'(HISTORY_DEPTH)) surfk_ff <= surf3;
      end

      // mean and differences
      if (state_ff == ST_MEAN) begin
         cv_ff  <= cv;
         ca_ff  <= ca;
         av_ff  <= av;
         k3s_ff <= k3 * surfk_ff;
         if (DEPTH_POW2) mean_ff <= 32'(sum_ff >>> IDX_W);
      end
      if (state_ff == ST_DIV && dcnt_ff == '0 && dmean_ff) begin
         mean_ff <= !dneg_ff ? 32'(dq_ff) :
                    (rem_ff != '0) ? 32'(-dq_ff) - 32'sd1 : 32'(-dq_ff);
      end

      // shared multiplier and accumulator
      if (state_ff == ST_MUL) begin
         prod_ff <= mul_a * mul_b;
         if (m_ff == 3'd0) begin
            acc_ff <= ACC_W'(sw_ff >>> 8) + ACC_W'(k3s_ff >>> 16);
         end else if (m_ff == 3'd5) begin
            acc_ff <= acc_ff - prod_term;
         end else begin
            acc_ff <= acc_ff + prod_term;
         end
      end

      if (state_ff == ST_FIN && rsp_free) rsp_data_ff <= drive_out;
   end

endmodule

`default_nettype wire

/* design/spsmc_checker.sv */
// port-level checks for the servo controller, bound to the top level
// depends on spsmc_pkg and the assertion macro header
`default_nettype none
`include "servo_pid_sliding_mode_controller_macros.svh"

module spsmc_checker
   import spsmc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a stalled response holds its value
   `SPSMC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // an accepted request makes the block busy, dropping ready
   `SPSMC_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready && $past(req_tready))

   // reset leaves no response pending and the block ready
   `SPSMC_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_tvalid && req_tready)

endmodule

bind servo_pid_sliding_mode_controller spsmc_checker u_spsmc_checker (.*);

`default_nettype wire

/* tb/servo_pid_sliding_mode_controller_tb.sv */
// testbench for the servo pid / sliding-mode controller: directed table, then random ticks
// depends on spsmc_pkg and servo_pid_sliding_mode_controller; checks against an in-bench predictor
`default_nettype none

module servo_pid_sliding_mode_controller_tb
   import spsmc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = spsmc_pkg::HISTORY_DEPTH;
   localparam int DRAIN_WAIT  = 120;

   logic        clock;
   logic        reset;
   logic [63:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;

   servo_pid_sliding_mode_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("servo_pid_sliding_mode_controller_tb: errors");
      $finish;
   end

   // controller state mirror
   logic signed [31:0] pos_hist [DEPTH];
   logic signed [31:0] tgt_hist [DEPTH];
   int unsigned        hist_idx;
   logic signed [31:0] tgt_latest, tgt_previous, tgt_slope;
   int unsigned        since_change, before_change;

   // register mirror
   longint             kp, ki, kvfb, kvff, kaff;
   logic [63:0]        smc_gains;
   longint             stat_band, oned_band;

   logic signed [31:0] drive_queue [$];
   int                 err_count = 0;
   int                 stall_pct = 0;
   int                 idle_pct = 0;
   int                 hold_cycles = 0;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic int unsigned back1(input int unsigned i);
      return (i + DEPTH - 1) % DEPTH;
   endfunction

   function automatic longint track_err(input int unsigned i);
      return clamp32(longint'(tgt_hist[i]) - longint'(pos_hist[back1(i)]));
   endfunction

   function automatic longint surface(input int unsigned i, input longint k1, k2);
      longint e;
      e = track_err(i);
      return k1 * e + k2 * clamp32(e - track_err(back1(i)));
   endfunction

   // advance the mirror by one tick and return the drive value
   function automatic logic signed [31:0] servo_tick(input logic signed [31:0] tin, pin);
      longint diff, e, cv, cvp, ca, av, sum, mean, drive, sw, ae, s;
      longint k1, k2, k3, k4;
      int unsigned k, km1, km2;
      k = hist_idx;
      km1 = back1(k);
      km2 = back1(km1);
      pos_hist[k] = pin;
      diff = longint'(tin) - longint'(tgt_latest);
      // stale or jump restarts the extrapolation
      if (since_change >= 2 * DEPTH || diff > JUMP_LIMIT || diff < -JUMP_LIMIT) begin
         tgt_latest = tin;
         tgt_previous = tin;
         since_change = 0;
         before_change = 0;
         tgt_slope = '0;
      end else if (diff != 0) begin
         tgt_previous = tgt_latest;
         tgt_latest = tin;
         before_change = since_change + 1;
         since_change = 0;
         tgt_slope = 32'(diff / longint'(before_change));
      end else begin
         since_change++;
      end
      tgt_hist[k] = 32'(clamp32(longint'(tgt_previous) +
                    longint'(since_change + before_change) * longint'(tgt_slope)));

      e   = track_err(k);
      cv  = clamp32(longint'(tgt_hist[k]) - longint'(tgt_hist[km1]));
      cvp = clamp32(longint'(tgt_hist[km1]) - longint'(tgt_hist[km2]));
      ca  = clamp32(cv - cvp);
      av  = clamp32(longint'(pos_hist[k]) - longint'(pos_hist[km1]));

      // floor of the mean error
      sum = 0;
      for (int i = 0; i < DEPTH; i++) sum += track_err(i);
      mean = sum / DEPTH;
      if (sum % DEPTH != 0 && sum < 0) mean--;

      k1 = longint'($signed(smc_gains[15:0]));
      k2 = longint'($signed(smc_gains[31:16]));
      k3 = longint'($signed(smc_gains[47:32]));
      k4 = longint'($signed(smc_gains[63:48]));

      // switching term over the whole history
      sw = 0;
      for (int i = 0; i < DEPTH; i++) begin
         s = surface(i, k1, k2);
         ae = track_err(i);
         if (ae < 0) ae = -ae;
         sw += (s < 0) ? -(k4 * ae) : k4 * ae;
      end

      drive = ((kp * e) >>> 16) + ((ki * mean) >>> 16) + ((kvff * cv) >>> 16)
            + ((kaff * ca) >>> 16) - ((kvfb * av) >>> 16)
            + ((k3 * surface(k, k1, k2)) >>> 16) + (sw >>> 8);
      drive = clamp32(drive);

      // deadbands
      ae = (e < 0) ? -e : e;
      if (ae < stat_band) begin
         drive = 0;
      end else if (ae < oned_band) begin
         if (tgt_slope < 0 && drive > 0) drive = 0;
         else if (tgt_slope > 0 && drive < 0) drive = 0;
      end
      hist_idx = (k + 1) % DEPTH;
      return 32'(drive);
   endfunction

   task automatic report_mismatch(input logic signed [31:0] got, want);
      $display("drive_value mismatch: got %0d expected %0d at %0t", got, want, $realtime);
      err_count++;
   endtask

   // response side: check and random stall, with long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (drive_queue.size() == 0) begin
               $display("unexpected response %0d at %0t", $signed(rsp_tdata), $realtime);
               err_count++;
            end else begin
               logic signed [31:0] want;
               want = drive_queue.pop_front();
               if ($signed(rsp_tdata) !== want) report_mismatch($signed(rsp_tdata), want);
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // one request; a fixed expectation overrides the predictor
   task automatic send_tick(input logic signed [31:0] tgt, meas,
                            input bit fixed, input logic signed [31:0] fixed_drive);
      logic signed [31:0] d;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {meas, tgt};
      do @(posedge clock); while (!req_tready);
      d = servo_tick(tgt, meas);
      drive_queue.push_back(fixed ? fixed_drive : d);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_GAIN_P:   kp = longint'($signed(val[31:0]));
         REG_GAIN_I:   ki = longint'($signed(val[31:0]));
         REG_GAIN_VFB: kvfb = longint'($signed(val[31:0]));
         REG_GAIN_VFF: kvff = longint'($signed(val[31:0]));
         REG_GAIN_AFF: kaff = longint'($signed(val[31:0]));
         REG_SMC:      smc_gains = val;
         REG_STAT_BND: stat_band = longint'(val[30:0]);
         REG_ONED_BND: oned_band = longint'(val[30:0]);
         default: ;
      endcase
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (drive_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] modest_gain();
      logic [31:0] g;
      g = $urandom_range(0, 32'h0004_0000);
      return $urandom_range(1) ? -g : g;
   endfunction

   // setting styles: 0 modest, 1 full random, 2 max, 3 min, 4 modest with bands
   task automatic configure(input int style);
      logic [31:0] g [5];
      logic [63:0] smc;
      logic [30:0] sb, ob;
      for (int i = 0; i < 5; i++) begin
         case (style)
            1: g[i] = $urandom;
            2: g[i] = 32'h7fff_ffff;
            3: g[i] = 32'h8000_0000;
            default: g[i] = modest_gain();
         endcase
      end
      case (style)
         1: smc = {$urandom, $urandom};
         2: smc = {4{16'h7fff}};
         3: smc = {4{16'h8000}};
         default: smc = {16'($urandom_range(0, 255)) - 16'd128,
                         16'($urandom_range(0, 511)) - 16'd256,
                         16'($urandom_range(0, 255)) - 16'd128,
                         16'($urandom_range(0, 255)) - 16'd128};
      endcase
      case (style)
         1: begin sb = 31'($urandom); ob = 31'($urandom); end
         2: begin sb = '0; ob = '1; end
         3: begin sb = '1; ob = '1; end
         4: begin sb = 31'($urandom_range(0, 32'h0002_0000));
                  ob = 31'($urandom_range(0, 32'h0008_0000)); end
         default: begin sb = '0; ob = '0; end
      endcase
      write_reg(REG_GAIN_P, {32'd0, g[0]});
      write_reg(REG_GAIN_I, {32'd0, g[1]});
      write_reg(REG_GAIN_VFB, {32'd0, g[2]});
      write_reg(REG_GAIN_VFF, {32'd0, g[3]});
      write_reg(REG_GAIN_AFF, {32'd0, g[4]});
      write_reg(REG_SMC, smc);
      write_reg(REG_STAT_BND, {$urandom, 1'b0, sb});
      write_reg(REG_ONED_BND, {$urandom, 1'b0, ob});
      csr_valid <= 1'b0;
   endtask

   // random ticks: mostly ramps and holds of a tracked target, some raw noise
   logic signed [31:0] walk_target = '0;

   task automatic random_ticks(input int count);
      int sent, hold, kind;
      logic signed [31:0] step, noise, meas;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(9);
         if (kind < 8) begin
            step = (kind < 2) ? 32'sd0 : $signed(32'($urandom_range(0, 1_400_000))) - 700_000;
            hold = $urandom_range(0, 40);
            walk_target = walk_target + step;
            for (int j = 0; j <= hold && sent < count; j++) begin
               noise = $signed(32'($urandom)) >>> $urandom_range(8, 31);
               meas = (kind == 7) ? $signed($urandom) : walk_target + noise;
               send_tick(walk_target, meas, 1'b0, '0);
               sent++;
            end
         end else begin
            send_tick($signed($urandom), $signed($urandom), 1'b0, '0);
            sent++;
         end
      end
   endtask

   typedef struct packed {
      logic signed [31:0] tgt;
      logic signed [31:0] meas;
      bit                 fixed;
      logic signed [31:0] drive;
   } tick_row_type;

   // first rows run with all gains zero after reset, so the drive is zero
   localparam int ZERO_ROWS = 4;
   localparam tick_row_type DIRECTED [20] = '{
      '{32'sh7fff_ffff, 32'sh8000_0000, 1'b1, 32'sd0},
      '{32'sh8000_0000, 32'sh7fff_ffff, 1'b1, 32'sd0},
      '{32'sd0, 32'sd0, 1'b1, 32'sd0},
      '{32'sh0000_ffff, -32'sd1, 1'b1, 32'sd0},
      '{32'sd0, 32'sd0, 1'b0, 32'sd0},
      '{32'sd65536, 32'sd0, 1'b0, 32'sd0},            // small step up sets slope
      '{32'sd65536, 32'sd30000, 1'b0, 32'sd0},        // hold extrapolates
      '{32'sd65536, 32'sd60000, 1'b0, 32'sd0},
      '{32'sd131072, 32'sd90000, 1'b0, 32'sd0},       // slope by division
      '{32'sd786432, 32'sd100000, 1'b0, 32'sd0},      // exactly ten degrees
      '{32'sd1441793, 32'sd100000, 1'b0, 32'sd0},     // just over: jump
      '{32'sd1400000, 32'sd1400000, 1'b0, 32'sd0},    // step down, negative slope
      '{32'sd1400000, 32'sd1500000, 1'b0, 32'sd0},
      '{32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 32'sd0},
      '{32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 32'sd0},
      '{32'sh8000_0000, 32'sh7fff_ffff, 1'b0, 32'sd0},
      '{32'sh8000_0000, 32'sh8000_0000, 1'b0, 32'sd0},
      '{-32'sd1, 32'sh7fff_ffff, 1'b0, 32'sd0},
      '{32'sh7ff0_0000, 32'sh8000_0001, 1'b0, 32'sd0},
      '{32'sh7ff5_0000, 32'sh8000_0001, 1'b0, 32'sd0} // positive slope near the top
   };

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pos_hist[i] = '0;
         tgt_hist[i] = '0;
      end
      hist_idx = 0;
      tgt_latest = '0;
      tgt_previous = '0;
      tgt_slope = '0;
      since_change = 0;
      before_change = 0;
      kp = 0; ki = 0; kvfb = 0; kvff = 0; kaff = 0;
      smc_gains = '0; stat_band = 0; oned_band = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int r = 0; r < $size(DIRECTED); r++) begin
         if (r == ZERO_ROWS) begin
            drain();
            configure(0);
         end
         send_tick(DIRECTED[r].tgt, DIRECTED[r].meas, DIRECTED[r].fixed, DIRECTED[r].drive);
      end
      drain();
      configure(2);
      for (int r = ZERO_ROWS; r < $size(DIRECTED); r++)
         send_tick(DIRECTED[r].tgt, DIRECTED[r].meas, 1'b0, '0);
      drain();
      configure(3);
      for (int r = ZERO_ROWS; r < $size(DIRECTED); r++)
         send_tick(DIRECTED[r].tgt, DIRECTED[r].meas, 1'b0, '0);

      // random phases with different idling
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         configure((ph == 1) ? 1 : (ph == 3) ? 4 : 0);
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 70; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 70; end
            3: begin idle_pct = 31; stall_pct = 31; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         // long receiver hold-off while requests keep coming
         if (ph == 4) hold_cycles = 600;
         random_ticks(ph == 4 ? 100 : 400);
      end
      idle_pct = 0;
      stall_pct = 0;
      drain();

      if (err_count == 0) begin
         $display("servo_pid_sliding_mode_controller_tb: clean");
      end else begin
         $display("servo_pid_sliding_mode_controller_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
